// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/btpp_pkg.sv =====
// Types and constants of the bracket text pretty printer
package btpp_pkg;

    localparam int DEPTH_W = 5;
    localparam int CNT_W   = DEPTH_W + 1;

    localparam logic [DEPTH_W-1:0] MAX_DEPTH = 5'd31;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic {
        CTL_IDLE,
        CTL_EMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        SEL_HEAD,
        SEL_NL,
        SEL_INDENT,
        SEL_TAIL
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        emit_sel_t sel;
        logic      last;
    } ctl_cmd_t;

    typedef struct packed {
        logic head_pend;
        logic nl_pend;
        logic indent_pend;
        logic indent_one;
        logic tail_pend;
        logic slot_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/btpp_datapath.sv =====
// Datapath: text state, decode of one item, emit plan and output register
`include "assert_macros.svh"

module btpp_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            char_in,
    input  logic                  start_text,
    input  btpp_pkg::ctl_cmd_t    cmd,
    output btpp_pkg::dp_status_t  sts,
    input  logic                  pretty_stall,
    output logic                  pretty_valid,
    output logic [7:0]            char_out,
    output logic                  last_of_run
);

    logic                          inside_quotes_reg;
    logic                          quote_is_single_reg;
    logic                          escape_pending_reg;
    logic [btpp_pkg::DEPTH_W-1:0]  nest_depth_reg;

    logic                          head_pend_reg;
    logic                          nl_pend_reg;
    logic                          tail_pend_reg;
    logic [btpp_pkg::CNT_W-1:0]    cnt_reg;
    logic [7:0]                    char_reg;
    logic [7:0]                    tail_byte_reg;

    logic                          out_valid_reg;
    logic [7:0]                    char_out_reg;
    logic                          last_reg;

    logic                          inside_quotes_next;
    logic                          quote_is_single_next;
    logic                          escape_pending_next;
    logic [btpp_pkg::DEPTH_W-1:0]  nest_depth_next;
    logic                          head_next;
    logic                          nl_next;
    logic                          tail_next;
    logic [7:0]                    tail_byte_next;
    logic [7:0]                    emit_byte;

    logic                          work_pend;
    logic                          out_held;

    // Decode one item against the state left by the previous one.
    always_comb
    begin
        logic                         q;
        logic                         s;
        logic                         e;
        logic [btpp_pkg::DEPTH_W-1:0] d;

        q = start_text ? 1'b0 : inside_quotes_reg;
        s = start_text ? 1'b0 : quote_is_single_reg;
        e = start_text ? 1'b0 : escape_pending_reg;
        d = start_text ? '0 : nest_depth_reg;

        inside_quotes_next   = q;
        quote_is_single_next = s;
        escape_pending_next  = e;
        nest_depth_next      = d;
        head_next            = 1'b0;
        nl_next              = 1'b0;
        tail_next            = 1'b0;
        tail_byte_next       = char_in;

        if (q)
        begin
            head_next = 1'b1;
            if (e)
            begin
                escape_pending_next = 1'b0;
            end
            else if (char_in == btpp_pkg::CH_BSLASH)
            begin
                escape_pending_next = 1'b1;
            end
            else if ((s && char_in == btpp_pkg::CH_SQUOTE) ||
                     (!s && char_in == btpp_pkg::CH_DQUOTE))
            begin
                inside_quotes_next   = 1'b0;
                quote_is_single_next = 1'b0;
            end
        end
        else if (char_in == btpp_pkg::CH_DQUOTE || char_in == btpp_pkg::CH_SQUOTE)
        begin
            inside_quotes_next   = 1'b1;
            quote_is_single_next = (char_in == btpp_pkg::CH_SQUOTE);
            escape_pending_next  = 1'b0;
            head_next            = 1'b1;
        end
        else
        begin
            case (char_in)
                btpp_pkg::CH_LBRACE, btpp_pkg::CH_LBRACK:
                begin
                    head_next = 1'b1;
                    nl_next   = 1'b1;
                    if (d < btpp_pkg::MAX_DEPTH)
                    begin
                        nest_depth_next = d + btpp_pkg::DEPTH_W'(1);
                    end
                end
                btpp_pkg::CH_RBRACE, btpp_pkg::CH_RBRACK:
                begin
                    nl_next   = 1'b1;
                    tail_next = 1'b1;
                    if (d != '0)
                    begin
                        nest_depth_next = d - btpp_pkg::DEPTH_W'(1);
                    end
                end
                btpp_pkg::CH_COMMA:
                begin
                    head_next = 1'b1;
                    nl_next   = 1'b1;
                end
                btpp_pkg::CH_COLON:
                begin
                    head_next      = 1'b1;
                    tail_next      = 1'b1;
                    tail_byte_next = btpp_pkg::CH_SPACE;
                end
                btpp_pkg::CH_SPACE:
                begin
                    head_next = 1'b0;
                end
                default:
                begin
                    head_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_quotes_reg   <= 1'b0;
            quote_is_single_reg <= 1'b0;
            escape_pending_reg  <= 1'b0;
            nest_depth_reg      <= '0;
            head_pend_reg       <= 1'b0;
            nl_pend_reg         <= 1'b0;
            tail_pend_reg       <= 1'b0;
            cnt_reg             <= '0;
        end
        else if (cmd.load)
        begin
            inside_quotes_reg   <= inside_quotes_next;
            quote_is_single_reg <= quote_is_single_next;
            escape_pending_reg  <= escape_pending_next;
            nest_depth_reg      <= nest_depth_next;
            head_pend_reg       <= head_next;
            nl_pend_reg         <= nl_next;
            tail_pend_reg       <= tail_next;
            // Indent only follows a newline: two spaces per level.
            cnt_reg             <= nl_next ? {nest_depth_next, 1'b0} : '0;
        end
        else if (cmd.emit)
        begin
            case (cmd.sel)
                btpp_pkg::SEL_HEAD:   head_pend_reg <= 1'b0;
                btpp_pkg::SEL_NL:     nl_pend_reg   <= 1'b0;
                btpp_pkg::SEL_INDENT: cnt_reg       <= cnt_reg - btpp_pkg::CNT_W'(1);
                btpp_pkg::SEL_TAIL:   tail_pend_reg <= 1'b0;
                default:              tail_pend_reg <= tail_pend_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg      <= char_in;
            tail_byte_reg <= tail_byte_next;
        end
    end

    always_comb
    begin
        case (cmd.sel)
            btpp_pkg::SEL_HEAD:   emit_byte = char_reg;
            btpp_pkg::SEL_NL:     emit_byte = btpp_pkg::CH_NL;
            btpp_pkg::SEL_INDENT: emit_byte = btpp_pkg::CH_SPACE;
            btpp_pkg::SEL_TAIL:   emit_byte = tail_byte_reg;
            default:              emit_byte = char_reg;
        endcase
    end

    // Output register: load on emit, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!pretty_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_out_reg <= emit_byte;
            last_reg     <= cmd.last;
        end
    end

    assign sts.head_pend   = head_pend_reg;
    assign sts.nl_pend     = nl_pend_reg;
    assign sts.indent_pend = (cnt_reg != '0);
    assign sts.indent_one  = (cnt_reg == btpp_pkg::CNT_W'(1));
    assign sts.tail_pend   = tail_pend_reg;
    assign sts.slot_free   = !out_valid_reg || !pretty_stall;

    assign pretty_valid = out_valid_reg;
    assign char_out     = char_out_reg;
    assign last_of_run  = last_reg;

    assign work_pend = head_pend_reg || nl_pend_reg || tail_pend_reg || (cnt_reg != '0);
    assign out_held  = out_valid_reg && pretty_stall;

    `ASSERT_IMPL(a_emit_has_work, cmd.emit, work_pend, "emit with nothing pending")
    `ASSERT_NEXT(a_last_drains, cmd.emit && cmd.last, !work_pend, "bytes left after last of run")
    `ASSERT_NEXT(a_out_hold, out_held, out_valid_reg && $stable(char_out_reg), "stalled item lost")

endmodule

// ===== hw/rtl/btpp_ctrl.sv =====
// Controller: accepts items and sequences the bytes of each run
`include "assert_macros.svh"

module btpp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  text_valid,
    output logic                  text_stall,
    input  btpp_pkg::dp_status_t  sts,
    output btpp_pkg::ctl_cmd_t    cmd
);

    btpp_pkg::ctl_state_t state_reg;
    btpp_pkg::ctl_state_t state_next;

    logic any_pend;

    assign any_pend = sts.head_pend || sts.nl_pend || sts.indent_pend || sts.tail_pend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btpp_pkg::CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        text_stall = 1'b1;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.sel    = btpp_pkg::SEL_HEAD;
        cmd.last   = 1'b0;

        case (state_reg)
            btpp_pkg::CTL_IDLE:
            begin
                text_stall = 1'b0;
                if (text_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = btpp_pkg::CTL_EMIT;
                end
            end
            btpp_pkg::CTL_EMIT:
            begin
                if (!any_pend)
                begin
                    // Dropped byte: no output for this item.
                    state_next = btpp_pkg::CTL_IDLE;
                end
                else if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.head_pend)
                    begin
                        cmd.sel  = btpp_pkg::SEL_HEAD;
                        cmd.last = !sts.nl_pend && !sts.indent_pend && !sts.tail_pend;
                    end
                    else if (sts.nl_pend)
                    begin
                        cmd.sel  = btpp_pkg::SEL_NL;
                        cmd.last = !sts.indent_pend && !sts.tail_pend;
                    end
                    else if (sts.indent_pend)
                    begin
                        cmd.sel  = btpp_pkg::SEL_INDENT;
                        cmd.last = sts.indent_one && !sts.tail_pend;
                    end
                    else
                    begin
                        cmd.sel  = btpp_pkg::SEL_TAIL;
                        cmd.last = 1'b1;
                    end
                    if (cmd.last)
                    begin
                        state_next = btpp_pkg::CTL_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = btpp_pkg::CTL_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_emit_slot_free, cmd.emit, sts.slot_free, "emit into a full output register")
    `ASSERT_IMPL(a_load_no_emit, cmd.load, !cmd.emit && !any_pend, "item taken during a run")
    `ASSERT_NEXT(a_load_to_emit, cmd.load, state_reg == btpp_pkg::CTL_EMIT, "no run after load")

endmodule

// ===== hw/rtl/bracket_text_pretty_printer_core.sv =====
// Top level of the bracket text pretty printer
//
//  channel   valid         stall         payload
//  text      text_valid    text_stall    char_in, start_text
//  pretty    pretty_valid  pretty_stall  char_out, last_of_run
//
// Each item is decoded when it is taken; without stalls on pretty its N bytes
// (1 to 64) then go one byte per cycle into the single output register.
// A dropped space emits nothing.
// Reset clears depth, quote and escape state and empties the output register.
// A stall on pretty holds the output register and pauses the run; text is
// taken again only once the last byte of the run is in the output register.
module bracket_text_pretty_printer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] char_in,
    input  logic       start_text,
    output logic       pretty_valid,
    input  logic       pretty_stall,
    output logic [7:0] char_out,
    output logic       last_of_run
);

    btpp_pkg::ctl_cmd_t   cmd;
    btpp_pkg::dp_status_t sts;

    btpp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    btpp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_in      (char_in),
        .start_text   (start_text),
        .cmd          (cmd),
        .sts          (sts),
        .pretty_stall (pretty_stall),
        .pretty_valid (pretty_valid),
        .char_out     (char_out),
        .last_of_run  (last_of_run)
    );

endmodule

// ===== dv/pretty_print_checker.sv =====
// Output predictor and stream checker for the bracket text pretty printer
`timescale 1ns / 1ps
module pretty_print_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    input  logic        text_stall,
    input  logic [7:0]  char_in,
    input  logic        start_text,
    input  logic        pretty_valid,
    input  logic        pretty_stall,
    input  logic [7:0]  char_out,
    input  logic        last_of_run,
    output int unsigned mismatches,
    output int unsigned bytes_owed
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } pretty_byte_t;

    pretty_byte_t owed_q[$];
    pretty_byte_t run_q[$];
    int unsigned  errs = 0;

    logic                          quoted        = 1'b0;
    logic                          single_quoted = 1'b0;
    logic                          escape_next   = 1'b0;
    logic [btpp_pkg::DEPTH_W-1:0]  depth         = '0;

    function automatic void put_byte(input logic [7:0] b);
        pretty_byte_t pb;
        pb.ch   = b;
        pb.last = 1'b0;
        run_q.push_back(pb);
    endfunction

    function automatic void put_indent();
        int k;
        for (k = 0; k < 2 * int'(depth); k++)
            put_byte(btpp_pkg::CH_SPACE);
    endfunction

    // Work out the bytes one text item produces and queue them.
    function automatic void format_char(input logic [7:0] c, input logic restart);
        run_q.delete();
        if (restart)
        begin
            quoted        = 1'b0;
            single_quoted = 1'b0;
            escape_next   = 1'b0;
            depth         = '0;
        end
        if (quoted)
        begin
            put_byte(c);
            if (escape_next)
                escape_next = 1'b0;
            else if (c == btpp_pkg::CH_BSLASH)
                escape_next = 1'b1;
            else if ((single_quoted && c == btpp_pkg::CH_SQUOTE) ||
                     (!single_quoted && c == btpp_pkg::CH_DQUOTE))
            begin
                quoted        = 1'b0;
                single_quoted = 1'b0;
            end
        end
        else if (c == btpp_pkg::CH_DQUOTE || c == btpp_pkg::CH_SQUOTE)
        begin
            quoted        = 1'b1;
            single_quoted = (c == btpp_pkg::CH_SQUOTE);
            escape_next   = 1'b0;
            put_byte(c);
        end
        else
        begin
            case (c)
                btpp_pkg::CH_LBRACE, btpp_pkg::CH_LBRACK:
                begin
                    put_byte(c);
                    put_byte(btpp_pkg::CH_NL);
                    if (depth < btpp_pkg::MAX_DEPTH)
                        depth = depth + btpp_pkg::DEPTH_W'(1);
                    put_indent();
                end
                btpp_pkg::CH_RBRACE, btpp_pkg::CH_RBRACK:
                begin
                    if (depth > 0)
                        depth = depth - btpp_pkg::DEPTH_W'(1);
                    put_byte(btpp_pkg::CH_NL);
                    put_indent();
                    put_byte(c);
                end
                btpp_pkg::CH_COMMA:
                begin
                    put_byte(c);
                    put_byte(btpp_pkg::CH_NL);
                    put_indent();
                end
                btpp_pkg::CH_COLON:
                begin
                    put_byte(btpp_pkg::CH_COLON);
                    put_byte(btpp_pkg::CH_SPACE);
                end
                btpp_pkg::CH_SPACE: ;
                default: put_byte(c);
            endcase
        end
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i])
            owed_q.push_back(run_q[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pretty_byte_t want;
        if (!rst_n)
        begin
            quoted        = 1'b0;
            single_quoted = 1'b0;
            escape_next   = 1'b0;
            depth         = '0;
            owed_q.delete();
            bytes_owed <= 0;
            mismatches <= errs;
        end
        else
        begin
            // Compare first: a byte on the output always belongs to an earlier item.
            if (pretty_valid && !pretty_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    $display("%0t: unexpected output byte: expected none, actual %h last %b",
                             $time, char_out, last_of_run);
                    errs++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (want.ch !== char_out)
                    begin
                        $display("%0t: char_out mismatch: expected %h, actual %h",
                                 $time, want.ch, char_out);
                        errs++;
                    end
                    if (want.last !== last_of_run)
                    begin
                        $display("%0t: last_of_run mismatch: expected %b, actual %b",
                                 $time, want.last, last_of_run);
                        errs++;
                    end
                end
            end
            if (text_valid && !text_stall)
                format_char(char_in, start_text);
            bytes_owed <= owed_q.size();
            mismatches <= errs;
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top: stimulus, handshake pacing and verdict for the pretty printer
`timescale 1ns / 1ps
module tb;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          RANDOM_ITEMS = 330;
    localparam int          DRAIN_CYCLES = 70;
    localparam int          LONG_HOLD    = 200;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       text_valid   = 1'b0;
    logic [7:0] char_in      = 8'h00;
    logic       start_text   = 1'b0;
    logic       pretty_stall = 1'b0;
    logic       text_stall;
    logic       pretty_valid;
    logic [7:0] char_out;
    logic       last_of_run;

    int unsigned mismatches;
    int unsigned bytes_owed;

    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_req       = 1'b0;
    int items_sent     = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bracket_text_pretty_printer_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .char_in      (char_in),
        .start_text   (start_text),
        .pretty_valid (pretty_valid),
        .pretty_stall (pretty_stall),
        .char_out     (char_out),
        .last_of_run  (last_of_run)
    );

    pretty_print_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .char_in      (char_in),
        .start_text   (start_text),
        .pretty_valid (pretty_valid),
        .pretty_stall (pretty_stall),
        .char_out     (char_out),
        .last_of_run  (last_of_run),
        .mismatches   (mismatches),
        .bytes_owed   (bytes_owed)
    );

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: short random stalls, plus one long hold on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pretty_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                pretty_stall <= 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 5) == 0)
            begin
                pretty_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                pretty_stall <= 1'b0;
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic restart);
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        char_in    <= c;
        start_text <= restart;
        text_valid <= 1'b1;
        do
            @(posedge clk);
        while (text_stall);
        items_sent++;
    endtask

    task automatic send_string();
        logic [7:0] quote;
        quote = $urandom_range(0, 1) ? btpp_pkg::CH_DQUOTE : btpp_pkg::CH_SQUOTE;
        send_char(quote, 1'b0);
        repeat ($urandom_range(0, 8))
        begin
            case ($urandom_range(0, 7))
                0:
                begin
                    send_char(btpp_pkg::CH_BSLASH, 1'b0);
                    send_char(8'($urandom_range(0, 255)), 1'b0);
                end
                1: send_char((quote == btpp_pkg::CH_DQUOTE) ? btpp_pkg::CH_SQUOTE
                                                            : btpp_pkg::CH_DQUOTE, 1'b0);
                2: send_char(8'($urandom_range(0, 255)), 1'b0);
                default: send_char(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
            endcase
        end
        send_char(quote, 1'b0);
    endtask

    function automatic logic [7:0] any_close();
        return $urandom_range(0, 1) ? btpp_pkg::CH_RBRACE : btpp_pkg::CH_RBRACK;
    endfunction

    function automatic logic [7:0] any_open();
        return $urandom_range(0, 1) ? btpp_pkg::CH_LBRACE : btpp_pkg::CH_LBRACK;
    endfunction

    // One document with random content; extra_levels nests straight down first.
    task automatic send_doc(input int extra_levels);
        int level;
        send_char(any_open(), 1'b1);
        level = 1;
        repeat (extra_levels)
        begin
            send_char(any_open(), 1'b0);
            level++;
        end
        repeat ($urandom_range(6, 30))
        begin
            case ($urandom_range(0, 11))
                0, 1:
                begin
                    send_char(any_open(), 1'b0);
                    level++;
                end
                2, 3:
                begin
                    if (level > 0)
                    begin
                        send_char(any_close(), 1'b0);
                        level--;
                    end
                end
                4: send_char(btpp_pkg::CH_COMMA, 1'b0);
                5: send_char(btpp_pkg::CH_COLON, 1'b0);
                6: send_char(btpp_pkg::CH_SPACE, 1'b0);
                7, 8: send_string();
                9: send_char(8'($urandom_range(8'h30, 8'h39)), 1'b0);
                10: send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                default: send_char(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
            endcase
        end
        while (level > 0)
        begin
            send_char(any_close(), 1'b0);
            level--;
        end
        // Sometimes close once too often.
        if ($urandom_range(0, 3) == 0)
            send_char(any_close(), 1'b0);
    endtask

    initial
    begin
        int  base;
        int  done;
        int  waited;
        bit  held;
        bit  paused;
        bit  deep_done;

        held      = 1'b0;
        paused    = 1'b0;
        deep_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: depth-zero close, dropped space, byte extremes, strings and escapes.
        send_char(btpp_pkg::CH_RBRACE, 1'b1);
        send_char(btpp_pkg::CH_SPACE,  1'b0);
        send_char(8'h00,               1'b0);
        send_char(8'hFF,               1'b0);
        send_char(btpp_pkg::CH_LBRACE, 1'b0);
        send_char(btpp_pkg::CH_DQUOTE, 1'b0);
        send_char(8'h61,               1'b0);
        send_char(btpp_pkg::CH_BSLASH, 1'b0);
        send_char(btpp_pkg::CH_DQUOTE, 1'b0);
        send_char(btpp_pkg::CH_DQUOTE, 1'b0);
        send_char(btpp_pkg::CH_COLON,  1'b0);
        send_char(btpp_pkg::CH_SQUOTE, 1'b0);
        send_char(btpp_pkg::CH_DQUOTE, 1'b0);
        send_char(btpp_pkg::CH_BSLASH, 1'b0);
        send_char(btpp_pkg::CH_SQUOTE, 1'b0);
        send_char(btpp_pkg::CH_SQUOTE, 1'b0);
        send_char(btpp_pkg::CH_COMMA,  1'b0);
        send_char(btpp_pkg::CH_LBRACK, 1'b0);
        send_char(btpp_pkg::CH_RBRACK, 1'b0);
        send_char(btpp_pkg::CH_RBRACE, 1'b0);
        send_char(btpp_pkg::CH_DQUOTE, 1'b0);
        send_char(btpp_pkg::CH_BSLASH, 1'b0);
        // Restart while an escape is pending inside a string.
        send_char(btpp_pkg::CH_SQUOTE, 1'b1);
        send_char(btpp_pkg::CH_SQUOTE, 1'b0);
        send_char(btpp_pkg::CH_RBRACK, 1'b0);

        base = items_sent;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            if (!held && done > 120)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!paused && done > 240)
            begin
                // Hold the sender until the output side has caught up.
                text_valid <= 1'b0;
                @(posedge clk);
                while (bytes_owed != 0)
                    @(posedge clk);
                paused = 1'b1;
            end
            if (done > 270)
            begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end
            if (!deep_done && done > 60)
            begin
                // Nest past the saturation level, then unwind below zero.
                send_doc(33);
                deep_done = 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(3, 10))
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            else
                send_doc(0);
            done = items_sent - base;
        end

        text_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (bytes_owed != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (bytes_owed != 0)
            $display("%0t: %0d expected bytes never arrived", $time, bytes_owed);
        if (mismatches == 0 && bytes_owed == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
